// ===== hw/rtl/ikht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ikht_pkg : shared types and constants
// Slot marks, status codes, operation codes and controller commands.
// ----------------------------------------------------------------------------
package ikht_pkg;

  localparam logic [1:0] OP_GET = 2'd0;
  localparam logic [1:0] OP_PUT = 2'd1;
  localparam logic [1:0] OP_DEL = 2'd2;

  localparam logic [1:0] MARK_EMPTY   = 2'd0;
  localparam logic [1:0] MARK_LIVE    = 2'd1;
  localparam logic [1:0] MARK_DELETED = 2'd2;

  localparam logic [1:0] ST_HIT      = 2'd0;
  localparam logic [1:0] ST_MISS     = 2'd1;
  localparam logic [1:0] ST_INSERTED = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [10:0] MAX_ITEMS_RST = 11'd819;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input transfer, start hash
    logic mix;       // advance one hash stage
    logic home;      // probe index := home slot, issue read
    logic rd;        // issue read at current index
    logic eval;      // inspect read data, step index
    logic commit;    // perform write / count update, form result
    logic clr;       // clearing pass step
  } ikht_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mix_done;
    logic walk_done;   // walk ended at this eval
    logic clr_done;
  } ikht_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/int64_key_hash_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// int64_key_hash_table : open-addressing hash table, 64-bit keys
// Get / put / delete with integer key mix and triangular probing.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the slot mark memory,
// holding in_ready low (cfg writes are taken throughout). Each transfer
// is then captured, run through the key mix (one mix stage a cycle), and
// issues the home slot read; each probe then waits for and evaluates a
// read of the single-port slot memories, which have registered data.
// Then a commit step writes the slot and the result is presented (held
// while out_ready is low). Only one item is in flight.
// status: 0 hit/replaced/removed, 1 miss, 2 inserted, 3 full.
// ----------------------------------------------------------------------------
module int64_key_hash_table #(
  parameter int SLOTS       = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_max_items,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [63:0] in_key,
  input  wire logic [31:0] in_value_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [31:0]      out_value_out,
  output logic [10:0]      out_live_count
);
  import ikht_pkg::*;

  ikht_cmd_t cmd;
  ikht_sts_t sts;

  // register is always writable
  assign cfg_ready = 1'b1;

  ikht_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .cmd(cmd), .sts(sts)
  );

  ikht_dp #(.SLOTS(SLOTS), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_max_items),
    .in_operation(in_operation), .in_key(in_key), .in_value_in(in_value_in),
    .out_status(out_status), .out_value_out(out_value_out),
    .out_live_count(out_live_count)
  );
endmodule
`default_nettype wire

// ===== hw/rtl/ikht_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ikht_ram : generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module ikht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/ikht_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ikht_ctrl : sequencer
// Clearing pass, hash, probe walk, commit and output hand-off.
// ----------------------------------------------------------------------------
module ikht_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ikht_pkg::ikht_cmd_t   cmd,
  input  wire ikht_pkg::ikht_sts_t sts
);
  import ikht_pkg::*;

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_MIX  = 8'b0000_0100,
    S_HOME = 8'b0000_1000,
    S_WAIT = 8'b0001_0000,
    S_EVAL = 8'b0010_0000,
    S_COMM = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        cmd.mix = 1'b1;
        if (sts.mix_done) state_nxt = S_HOME;
      end
      S_HOME: begin
        cmd.home  = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.walk_done ? S_COMM : S_WAIT;
        if (!sts.walk_done) cmd.rd = 1'b1;
      end
      S_COMM: begin
        cmd.commit = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLR;
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/ikht_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ikht_dp : datapath
// Key mix, probe index, slot memories, walk tracking and result registers.
// ----------------------------------------------------------------------------
module ikht_dp #(
  parameter int SLOTS       = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire ikht_pkg::ikht_cmd_t    cmd,
  output ikht_pkg::ikht_sts_t         sts,
  input  wire logic                   cfg_valid,
  input  wire logic                   cfg_ready,
  input  wire logic [10:0]            cfg_data,
  input  wire logic [1:0]             in_operation,
  input  wire logic [63:0]            in_key,
  input  wire logic [31:0]            in_value_in,
  output logic [1:0]                  out_status,
  output logic [31:0]                 out_value_out,
  output logic [10:0]                 out_live_count
);
  import ikht_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int CW = AW + 1;

  logic [10:0]            max_items_r;
  logic [CW-1:0]          count_r;
  logic [1:0]             op_r;
  logic [63:0]            key_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [63:0]            h_r;
  logic [2:0]             hstep_r;
  logic [AW-1:0]          idx_r;
  logic [CW-1:0]          n_r;
  logic                   found_r, have_spot_r;
  logic [AW-1:0]          hit_r, spot_r;
  logic [AW-1:0]          clr_idx_r;
  logic                   clr_done_r;
  logic [1:0]             status_r;
  logic [VALUE_WIDTH-1:0] vout_r;

  // memories
  logic                   mem_we;
  logic [AW-1:0]          mem_addr;
  logic [63:0]            key_wd, key_rd;
  logic [VALUE_WIDTH-1:0] val_wd, val_rd;
  logic [1:0]             mark_wd, mark_rd;
  logic                   key_we, val_we, mark_we;

  ikht_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_key (
    .clk(clk), .we(key_we), .addr(mem_addr), .wdata(key_wd), .rdata(key_rd));
  ikht_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(SLOTS)) u_val (
    .clk(clk), .we(val_we), .addr(mem_addr), .wdata(val_wd), .rdata(val_rd));
  ikht_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_mark (
    .clk(clk), .we(mark_we), .addr(mem_addr), .wdata(mark_wd), .rdata(mark_rd));

  // hash stages, one per cycle
  logic [63:0] h_nxt;
  always_comb begin
    case (hstep_r)
      3'd0:    h_nxt = (~h_r) + (h_r << 21);
      3'd1:    h_nxt = h_r ^ (h_r >> 24);
      3'd2:    h_nxt = h_r + (h_r << 3) + (h_r << 8);
      3'd3:    h_nxt = h_r ^ (h_r >> 14);
      3'd4:    h_nxt = h_r + (h_r << 2) + (h_r << 4);
      3'd5:    h_nxt = h_r ^ (h_r >> 28);
      3'd6:    h_nxt = h_r + (h_r << 31);
      default: h_nxt = h_r;
    endcase
  end

  // walk evaluation
  logic is_live, is_del, key_eq, walk_end, is_hit;
  logic [CW-1:0] n_inc;
  assign is_live  = (mark_rd == MARK_LIVE);
  assign is_del   = (mark_rd == MARK_DELETED);
  assign key_eq   = (key_rd == key_r);
  assign is_hit   = is_live && key_eq;
  assign n_inc    = n_r + CW'(1);
  assign walk_end = is_hit || (!is_live && !is_del) || (n_inc == CW'(SLOTS));

  logic ins_ok;
  assign ins_ok = (12'(count_r) < {1'b0, max_items_r}) && have_spot_r;

  always_comb begin
    key_we   = 1'b0;
    val_we   = 1'b0;
    mark_we  = 1'b0;
    mem_addr = idx_r;
    key_wd   = key_r;
    val_wd   = val_r;
    mark_wd  = MARK_LIVE;
    if (cmd.clr) begin
      mem_addr = clr_idx_r;
      mark_we  = 1'b1;
      mark_wd  = MARK_EMPTY;
    end else if (cmd.home) begin
      mem_addr = h_r[AW-1:0];
    end else if (cmd.rd) begin
      mem_addr = idx_r + n_inc[AW-1:0];
    end else if (cmd.commit) begin
      if (op_r == OP_PUT) begin
        if (found_r) begin
          mem_addr = hit_r;
          val_we   = 1'b1;
        end else if (ins_ok) begin
          mem_addr = spot_r;
          key_we   = 1'b1;
          val_we   = 1'b1;
          mark_we  = 1'b1;
        end
      end else if (op_r == OP_DEL && found_r) begin
        mem_addr = hit_r;
        mark_we  = 1'b1;
        mark_wd  = MARK_DELETED;
      end
    end
  end
  assign mem_we = key_we | val_we | mark_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_items_r <= MAX_ITEMS_RST;
      count_r     <= '0;
      clr_idx_r   <= '0;
      clr_done_r  <= 1'b0;
      hstep_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) max_items_r <= cfg_data;
      if (cmd.clr) begin
        clr_idx_r <= clr_idx_r + AW'(1);
        if (clr_idx_r == AW'(SLOTS - 2)) clr_done_r <= 1'b1;
      end
      if (cmd.load) hstep_r <= '0;
      if (cmd.mix)  hstep_r <= hstep_r + 3'd1;
      if (cmd.commit && mem_we) begin
        if (op_r == OP_PUT && !found_r) count_r <= count_r + CW'(1);
        if (op_r == OP_DEL && count_r != '0) count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_operation;
      key_r <= in_key;
      h_r   <= in_key;
      val_r <= in_value_in[VALUE_WIDTH-1:0];
    end
    if (cmd.mix) h_r <= h_nxt;
    if (cmd.home) begin
      idx_r       <= h_r[AW-1:0];
      n_r         <= '0;
      found_r     <= 1'b0;
      have_spot_r <= 1'b0;
      spot_r      <= '0;
    end
    if (cmd.eval) begin
      if (is_hit) begin
        found_r <= 1'b1;
        hit_r   <= idx_r;
      end else if (!is_live && !have_spot_r) begin
        have_spot_r <= 1'b1;
        spot_r      <= idx_r;
      end
      if (is_hit) vout_r <= val_rd;
      idx_r <= idx_r + n_inc[AW-1:0];
      n_r   <= n_inc;
    end
    if (cmd.commit) begin
      status_r <= ST_MISS;
      if (op_r == OP_GET || op_r == OP_DEL) begin
        if (found_r) status_r <= ST_HIT;
        else         vout_r   <= '0;
      end else if (op_r == OP_PUT) begin
        vout_r <= '0;
        if (found_r)     status_r <= ST_HIT;
        else if (ins_ok) status_r <= ST_INSERTED;
        else             status_r <= ST_FULL;
      end else begin
        vout_r <= '0;
      end
    end
  end

  assign sts.mix_done  = (hstep_r == 3'd6);
  assign sts.walk_done = walk_end || (op_r != OP_GET && op_r != OP_PUT && op_r != OP_DEL);
  assign sts.clr_done  = clr_done_r;

  assign out_status     = status_r;
  assign out_value_out  = 32'(vout_r);
  assign out_live_count = 11'(count_r);
endmodule
`default_nettype wire
